// ===== sv/top_k_climb_budget_tracker_top_macros.svh =====
// Assertion shorthands for the files that assert.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef TOP_K_CLIMB_BUDGET_TRACKER_TOP_MACROS_SVH
`define TOP_K_CLIMB_BUDGET_TRACKER_TOP_MACROS_SVH

// Same-cycle implication.
`define TKCB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TKCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tkcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tkcb_pkg;

	// fixed field widths
	localparam int IDX_W      = 32;
	localparam int SUM_W      = 32;
	localparam int LADDER_W   = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BRICK_BUDGET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LADDER_COUNT = 1'd1;

endpackage
`default_nettype wire

// ===== sv/tkcb_heap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tkcb_heap_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 24,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [WIDTH-1:0]  rdata_a,
	output logic      [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ===== sv/top_k_climb_budget_tracker_top.sv =====
// Path, acceptance to out_valid: IDLE, CALC, DONE for a start or stopped word; IDLE, CALC,
//   DECIDE, DONE for bricks with the heap untouched; a push or a replace adds a sift walk.
// Words: a new word is taken only back in IDLE, after the last result is loaded; DONE waits
//   while out_valid is held and out_ready is low; the sift walk runs one RD/CMP pair a heap level.
// Reset: arst_n clears registers, fill count, sum, index, stop flag and out_valid at once;
//   heap memory is not cleared, only entries below the fill count are ever used.
`timescale 1ns / 1ps
`default_nettype none
`include "top_k_climb_budget_tracker_top_macros.svh"
module top_k_climb_budget_tracker_top #(
	parameter int HEAP_DEPTH  = 16,
	parameter int HEIGHT_BITS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [tkcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tkcb_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input words
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [HEIGHT_BITS-1:0]            height,
	input  wire logic                              first,
	// result words
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   reachable,
	output logic      [tkcb_pkg::IDX_W-1:0]        furthest_index,
	output logic      [tkcb_pkg::SUM_W-1:0]        bricks_used
);

	import tkcb_pkg::*;

	// heap address, fill count and child index widths
	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int LW = $clog2(2 * HEAP_DEPTH + 1);

	// Sequencer:
	//   IDLE   - take a word
	//   CALC   - start-of-sequence clear, stopped pass, or form the rise
	//   DECIDE - push when below the ladder limit, else pay bricks and
	//            maybe replace the heap minimum
	//   UP_*   - sift-up of a pushed rise, one level per RD/CMP pair
	//   DN_*   - sift-down of a replacing rise, one level per RD/CMP pair
	//   DONE   - load the output register once it is free
	// The moving rise is never stored until its final slot is known: each
	// level moves one neighbor into the hole and the rise lands last.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DECIDE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	state_t                   state_q;

	// configuration registers
	logic [31:0]              budget_q;
	logic [LADDER_W-1:0]      ladder_q;

	// accepted word and sequence state
	logic [HEIGHT_BITS-1:0]   h_q;
	logic                     first_q;
	logic [HEIGHT_BITS-1:0]   rise_q;
	logic [HEIGHT_BITS-1:0]   prev_q;
	logic [CW-1:0]            fill_q;
	logic [SUM_W-1:0]         sum_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     stopped_q;
	logic [AW-1:0]            pos_q;

	// heap memory ports
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [HEIGHT_BITS-1:0]   ram_wdata;
	logic [AW-1:0]            ram_raddr_a;
	logic [AW-1:0]            ram_raddr_b;
	logic [HEIGHT_BITS-1:0]   ram_rdata_a;
	logic [HEIGHT_BITS-1:0]   ram_rdata_b;

	// shared datapath
	logic [CW-1:0]            limit;
	logic [IDX_W-1:0]         idx_next;
	logic                     top_lt;
	logic [HEIGHT_BITS-1:0]   pay;
	logic [SUM_W:0]           wide_sum;
	logic [SUM_W-1:0]         sat_sum;
	logic                     exceed;
	logic [LW-1:0]            left_idx;
	logic [LW-1:0]            right_idx;
	logic                     left_take;
	logic                     right_take;
	logic [HEIGHT_BITS-1:0]   min_val;
	logic [AW-1:0]            parent_idx;

	tkcb_heap_ram #(
		.DEPTH  (HEAP_DEPTH),
		.WIDTH  (HEIGHT_BITS),
		.ADDR_W (AW)
	) u_heap_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	assign in_ready = (state_q == ST_IDLE);

	// Clamp the ladder count to the heap depth.
	always_comb begin
		if (32'(ladder_q) > 32'(HEAP_DEPTH)) begin
			limit = CW'(HEAP_DEPTH);
		end else begin
			limit = CW'(ladder_q);
		end
	end

	assign idx_next = (idx_q == '1) ? idx_q : idx_q + 1'b1;

	// Port A rests on the root, so in DECIDE it shows the heap minimum.
	assign top_lt   = (fill_q != '0) && (ram_rdata_a < rise_q);
	assign pay      = top_lt ? ram_rdata_a : rise_q;
	assign wide_sum = {1'b0, sum_q} + (SUM_W + 1)'(pay);
	assign sat_sum  = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
	// exact sum against the budget, so saturation cannot hide an overrun
	assign exceed   = wide_sum > {1'b0, budget_q};

	// children of the hole for sift-down, parent for sift-up
	assign left_idx   = (LW'(pos_q) << 1) + LW'(1);
	assign right_idx  = left_idx + LW'(1);
	assign left_take  = (left_idx < LW'(fill_q)) && (ram_rdata_a < rise_q);
	assign min_val    = left_take ? ram_rdata_a : rise_q;
	assign right_take = (right_idx < LW'(fill_q)) && (ram_rdata_b < min_val);
	assign parent_idx = (pos_q - 1'b1) >> 1;

	// heap memory control
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = rise_q;
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		case (state_q)
			ST_UP_RD: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr_a = parent_idx;
				end
			end
			ST_UP_CMP: begin
				// move a larger parent down into the hole, else drop the rise there
				ram_we = 1'b1;
				if (ram_rdata_a > rise_q) begin
					ram_wdata = ram_rdata_a;
				end
			end
			ST_DN_RD: begin
				ram_raddr_a = left_idx[AW-1:0];
				ram_raddr_b = right_idx[AW-1:0];
			end
			ST_DN_CMP: begin
				// move the smaller child up into the hole, else drop the rise there
				ram_we = 1'b1;
				if (right_take) begin
					ram_wdata = ram_rdata_b;
				end else if (left_take) begin
					ram_wdata = ram_rdata_a;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
			ladder_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRICK_BUDGET: budget_q <= cfg_data[31:0];
				REG_LADDER_COUNT: ladder_q <= cfg_data[LADDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, sequence state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			h_q            <= '0;
			first_q        <= 1'b0;
			rise_q         <= '0;
			prev_q         <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
			idx_q          <= '0;
			stopped_q      <= 1'b0;
			pos_q          <= '0;
			out_valid      <= 1'b0;
			reachable      <= 1'b0;
			furthest_index <= '0;
			bricks_used    <= '0;
		end else begin
			// drop a taken result; DONE reloads the register itself
			if (out_valid && out_ready && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						h_q     <= height;
						first_q <= first;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (first_q) begin
						// new sequence: clear everything, this building is index 0
						fill_q    <= '0;
						sum_q     <= '0;
						idx_q     <= '0;
						stopped_q <= 1'b0;
						prev_q    <= h_q;
						state_q   <= ST_DONE;
					end else if (stopped_q) begin
						state_q <= ST_DONE;
					end else begin
						rise_q  <= (h_q > prev_q) ? h_q - prev_q : '0;
						prev_q  <= h_q;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (fill_q < limit) begin
						// ladder still free: push the rise at the end
						pos_q   <= fill_q[AW-1:0];
						fill_q  <= fill_q + 1'b1;
						idx_q   <= idx_next;
						state_q <= ST_UP_RD;
					end else begin
						sum_q <= sat_sum;
						if (exceed) begin
							stopped_q <= 1'b1;
						end else begin
							idx_q <= idx_next;
						end
						if (top_lt) begin
							pos_q   <= '0;
							state_q <= ST_DN_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_UP_RD: begin
					if (pos_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_UP_CMP;
					end
				end
				ST_UP_CMP: begin
					if (ram_rdata_a > rise_q) begin
						pos_q   <= parent_idx;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DN_RD: begin
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (right_take) begin
						pos_q   <= right_idx[AW-1:0];
						state_q <= ST_DN_RD;
					end else if (left_take) begin
						pos_q   <= left_idx[AW-1:0];
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid || out_ready) begin
						out_valid      <= 1'b1;
						reachable      <= !stopped_q;
						furthest_index <= idx_q;
						bricks_used    <= sum_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill count never passes the heap depth
	`TKCB_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CW'(HEAP_DEPTH), "heap fill beyond depth")

	// a stopped sequence leaves its sum and index alone and goes straight to DONE
	`TKCB_ASSERT_NEXT(a_stopped_frozen, (state_q == ST_CALC) && !first_q && stopped_q, $stable(sum_q) && $stable(idx_q) && (state_q == ST_DONE), "stopped word changed state")

	// paying bricks never lowers the sum
	`TKCB_ASSERT_NEXT(a_sum_monotonic, state_q == ST_DECIDE, sum_q >= $past(sum_q), "brick sum decreased")

endmodule
`default_nettype wire
